// File: rtl/cms_pkg.sv
package cms_pkg;

    // Item operations
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_MIN    = 3'd2;
    localparam logic [2:0] MODE_MEAN   = 3'd3;
    localparam logic [2:0] MODE_MMIN   = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    // Configuration register indexes
    localparam logic [0:0] REG_ROW_WIDTH = 1'b0;
    localparam logic [0:0] REG_ROW_COUNT = 1'b1;

    localparam int HASH_INPUTS = 4;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    // Shared divider request and answer
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return INT_MAX;
        end else if (v < -36'sd2147483648) begin
            return INT_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// File: rtl/cms_div.sv
// Restoring divider, one quotient bit a cycle. Unsigned magnitude divide; the
// quotient is negated at the end when neg is set (truncating signed divide).
module cms_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  cms_pkg::div_req_t req,
    output cms_pkg::div_rsp_t rsp
);
    import cms_pkg::*;

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [16:0] trial;

    assign trial = {rem_reg[15:0], quo_reg[63]} - {1'b0, dvs_reg};

    // Shift one dividend bit in per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                neg_reg  <= req.neg;
            end else if (busy_reg) begin
                if (trial[16]) begin
                    rem_reg <= {rem_reg[15:0], quo_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = neg_reg ? (64'd0 - quo_reg) : quo_reg;
    assign rsp.remainder = rem_reg[15:0];

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> $past(busy_reg)) else $error("divider done without work");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start) else $error("divider restarted while busy");
    a_cnt_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |=> !busy_reg || $past(req.start))
        else $error("divider woke without start");
`endif

endmodule

// File: rtl/count_min_sketch_engine.sv
// Count-min sketch engine.
// Input: s_tvalid/s_tready/s_tdata carry one item (mode, amount, hash_count,
// four 64-bit hashes). Output: m_tvalid/m_tready/m_tdata give one result per
// item (estimate, status). Configuration: cfg_we/cfg_index/cfg_wdata write
// row_width (index 0) and row_count (index 1); the user must write them only
// while idle; the block itself does not enforce it. Each item is processed
// by a sequencer around one shared bit-serial divider and one counter memory
// with one write port and one read port: per used row a hash modulo, a memory
// read and an optional write; mean-min adds one divide per row, a short sort
// and, for an even row count, a halving; mean adds one final divide. Items
// short of hashes or of an unused mode go straight to the result. The divider
// yields one quotient bit per cycle. Clear sweeps the whole memory, one
// counter per cycle; after reset the same clearing pass runs before s_tready
// rises. The result sits in an output register; while m_tready is low it holds
// and no new item is taken until it is transferred.
module count_min_sketch_engine #(
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int MAX_ROWS      = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], amount[33:3], hash_count[36:34], hash_0..hash_3 [292:37]
    input  logic [295:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // estimate[31:0], status[32]
    output logic [39:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_wdata
);
    import cms_pkg::*;

    localparam int DEPTH = MAX_ROW_WIDTH * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_ROW_WIDTH + 1);
    localparam int RCAP  = (MAX_ROWS < HASH_INPUTS) ? MAX_ROWS : HASH_INPUTS;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_HWAIT = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_RDAT  = 4'd5;
    localparam logic [3:0] S_MWAIT = 4'd6;
    localparam logic [3:0] S_SORT  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_FWAIT = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]  state_reg;
    logic [AW:0] clr_reg;
    logic [10:0] rw_reg;
    logic [2:0]  rc_reg;

    logic [2:0]  mode_reg;
    logic [30:0] amt_reg;
    logic [63:0] hash_reg [HASH_INPUTS];
    logic [1:0]  row_reg;
    logic [AW-1:0] addr_reg;
    logic signed [31:0] total_reg;
    logic signed [33:0] acc_reg;   // min or sum
    logic signed [33:0] v_reg [HASH_INPUTS];
    logic [1:0]  sort_reg;
    logic signed [31:0] est_reg;
    logic        stat_reg;
    logic        mval_reg;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    cms_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Effective configuration
    logic [WW-1:0] w_eff;
    logic [2:0]    r_eff;
    always_comb begin
        if (rw_reg < 11'd2) begin
            w_eff = WW'(2);
        end else if ({21'd0, rw_reg} > 32'(MAX_ROW_WIDTH)) begin
            w_eff = WW'(MAX_ROW_WIDTH);
        end else begin
            w_eff = WW'(rw_reg);
        end
        if (rc_reg == 3'd0) begin
            r_eff = 3'd1;
        end else if ({29'd0, rc_reg} > 32'(RCAP)) begin
            r_eff = 3'(RCAP);
        end else begin
            r_eff = rc_reg;
        end
    end

    // Counter update
    logic signed [35:0] upd;
    logic signed [31:0] upd_sat;
    logic signed [35:0] tot_upd;
    always_comb begin
        upd     = 36'(rdata_reg);
        tot_upd = 36'(total_reg);
        if (mode_reg == MODE_ADD) begin
            upd     = 36'(rdata_reg) + 36'({1'b0, amt_reg});
            tot_upd = 36'(total_reg) + 36'({1'b0, amt_reg});
        end else if (mode_reg == MODE_REMOVE) begin
            upd     = 36'(rdata_reg) - 36'({1'b0, amt_reg});
            tot_upd = 36'(total_reg) - 36'({1'b0, amt_reg});
        end
        upd_sat = sat32(upd);
    end

    // Mean-min numerator: total - counter
    logic signed [33:0] diff;
    assign diff = 34'(total_reg) - 34'(rdata_reg);

    // Final mean divide operand, or the median (middle-pair sum for even rows)
    logic signed [35:0] fin_num;
    assign fin_num = (mode_reg == MODE_MEAN) ? 36'(acc_reg)
        : ((r_eff[0]) ? 36'(v_reg[r_eff[2:1]])
                      : 36'(v_reg[2'(r_eff[2:1])]) + 36'(v_reg[2'(r_eff[2:1] - 2'd1)]));

    // Halve the median sum, rounding toward zero
    logic signed [35:0] med_sum;
    logic signed [35:0] med_half;
    assign med_sum  = fin_num + (fin_num[35] ? 36'sd1 : 36'sd0);
    assign med_half = med_sum >>> 1;

    logic [1:0] rows_m1;
    assign rows_m1 = 2'(r_eff - 3'd1);

    logic [AW-1:0] index_calc;
    assign index_calc = AW'(drsp.remainder) + AW'(32'(row_reg) * 32'(w_eff));

    always_comb begin
        dreq = '0;
        if (state_reg == S_HASH) begin
            dreq.start    = 1'b1;
            dreq.dividend = hash_reg[row_reg];
            dreq.divisor  = 16'(w_eff);
        end else if (state_reg == S_RDAT && mode_reg == MODE_MMIN) begin
            dreq.start    = 1'b1;
            dreq.neg      = diff[33];
            dreq.dividend = 64'(diff[33] ? -diff : diff);
            dreq.divisor  = 16'(w_eff - WW'(1));
        end else if (state_reg == S_FIN && mode_reg == MODE_MEAN) begin
            dreq.start    = 1'b1;
            dreq.neg      = fin_num[35];
            dreq.dividend = 64'(fin_num[35] ? -fin_num : fin_num);
            dreq.divisor  = 16'(r_eff);
        end
    end

    // Counter memory, one write port and one read port
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic signed [31:0] mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = upd_sat;
        if (state_reg == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = clr_reg[AW-1:0];
            mem_wd = '0;
        end else if (state_reg == S_RDAT && (mode_reg == MODE_ADD || mode_reg == MODE_REMOVE)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[addr_reg];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            rw_reg    <= 11'd1024;
            rc_reg    <= 3'd4;
            total_reg <= '0;
            mval_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_ROW_WIDTH) begin
                    rw_reg <= cfg_wdata;
                end else begin
                    rc_reg <= cfg_wdata[2:0];
                end
            end
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1)) begin
                        state_reg <= mval_reg ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg    <= s_tdata[2:0];
                        amt_reg     <= s_tdata[33:3];
                        for (int i = 0; i < HASH_INPUTS; i++) begin
                            hash_reg[i] <= s_tdata[37 + 64*i +: 64];
                        end
                        row_reg  <= '0;
                        sort_reg <= 2'd1;
                        acc_reg  <= (s_tdata[2:0] == MODE_MEAN) ? '0 : 34'(INT_MAX);
                        est_reg  <= '0;
                        stat_reg <= 1'b0;
                        if (s_tdata[2:0] == MODE_CLEAR) begin
                            total_reg <= '0;
                            clr_reg   <= '0;
                            mval_reg  <= 1'b1;
                            state_reg <= S_CLR;
                        end else if (s_tdata[2:0] > MODE_CLEAR) begin
                            mval_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end else if (s_tdata[36:34] < r_eff) begin
                            stat_reg  <= 1'b1;
                            mval_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH: state_reg <= S_HWAIT;
                S_HWAIT: begin
                    if (drsp.done) begin
                        addr_reg  <= index_calc;
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_RDAT;
                S_RDAT: begin
                    if (mode_reg == MODE_ADD || mode_reg == MODE_REMOVE) begin
                        if (34'(upd_sat) < acc_reg) acc_reg <= 34'(upd_sat);
                    end else if (mode_reg == MODE_MIN) begin
                        if (34'(rdata_reg) < acc_reg) acc_reg <= 34'(rdata_reg);
                    end else if (mode_reg == MODE_MEAN) begin
                        acc_reg <= acc_reg + 34'(rdata_reg);
                    end
                    if (mode_reg == MODE_MMIN) begin
                        state_reg <= S_MWAIT;
                    end else if (row_reg == rows_m1) begin
                        if (mode_reg == MODE_MEAN) begin
                            state_reg <= S_FIN;
                        end else begin
                            if (mode_reg != MODE_MIN) total_reg <= sat32(tot_upd);
                            if (mode_reg != MODE_MIN) begin
                                est_reg <= (34'(upd_sat) < acc_reg) ? upd_sat : acc_reg[31:0];
                            end else begin
                                est_reg <= (34'(rdata_reg) < acc_reg) ? rdata_reg
                                                                       : acc_reg[31:0];
                            end
                            mval_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= S_HASH;
                    end
                end
                S_MWAIT: begin
                    if (drsp.done) begin
                        v_reg[row_reg] <= 34'(rdata_reg) - 34'(signed'(drsp.quotient[33:0]));
                        if (row_reg == rows_m1) begin
                            state_reg <= S_SORT;
                        end else begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_SORT: begin
                    // bubble pass one adjacent compare per cycle
                    if (r_eff == 3'd1) begin
                        state_reg <= S_FIN;
                    end else begin
                        if (v_reg[sort_reg - 2'd1] > v_reg[sort_reg]) begin
                            v_reg[sort_reg - 2'd1] <= v_reg[sort_reg];
                            v_reg[sort_reg]        <= v_reg[sort_reg - 2'd1];
                            sort_reg <= 2'd1;
                        end else if (sort_reg == rows_m1) begin
                            state_reg <= S_FIN;
                        end else begin
                            sort_reg <= sort_reg + 2'd1;
                        end
                    end
                end
                S_FIN: begin
                    // Median goes straight out; mean waits for the divide
                    if (mode_reg == MODE_MMIN) begin
                        est_reg   <= sat32(r_eff[0] ? fin_num : med_half);
                        mval_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    if (drsp.done) begin
                        est_reg   <= sat32(36'(signed'(drsp.quotient[35:0])));
                        mval_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        mval_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg && (state_reg == S_OUT);
    assign m_tdata  = {7'd0, stat_reg, est_reg};

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    a_idle_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> s_tready) else $error("no return to idle");
    a_status_zero_est: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && stat_reg) |-> est_reg == 32'sd0) else $error("short item with estimate");
`endif

endmodule

// File: dv/count_min_sketch_engine_tb.sv
`timescale 1ns / 1ps

module count_min_sketch_engine_tb;
    import cms_pkg::*;

    localparam int ROW_CAP   = 1024;
    localparam int ROWS_CAP  = 4;
    localparam int DEPTH     = ROW_CAP * ROWS_CAP;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [31:0] estimate;
        logic               status;
    } sketch_result_t;

    typedef logic [3:0][63:0] hash_set_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [295:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_index = REG_ROW_WIDTH;
    logic [10:0]  cfg_wdata = '0;

    // Shadow of the sketch state and registers
    logic signed [31:0] shadow_table [DEPTH];
    logic signed [31:0] shadow_total;
    logic [10:0]        shadow_width_reg;
    logic [2:0]         shadow_rows_reg;

    sketch_result_t pending_results [$];
    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold_cycles = 0;
    hash_set_t key_pool [16];

    always #5 aclk = ~aclk;

    count_min_sketch_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(INT_MAX)) return INT_MAX;
        if (v < longint'(INT_MIN)) return INT_MIN;
        return v[31:0];
    endfunction

    // Apply one item to the shadow state and return its result
    function automatic sketch_result_t sketch_apply(input logic [2:0] mode,
                                                    input logic [30:0] amount,
                                                    input logic [2:0] hash_count,
                                                    input hash_set_t hashes);
        sketch_result_t res;
        longint unsigned w;
        longint unsigned k;
        int rows;
        int slot [4];
        longint vals [4];
        longint est;
        longint c;
        longint m;
        longint t;
        int b;
        w = shadow_width_reg;
        if (w < 2) w = 2;
        if (w > ROW_CAP) w = ROW_CAP;
        rows = shadow_rows_reg;
        if (rows < 1) rows = 1;
        if (rows > ROWS_CAP) rows = ROWS_CAP;
        est = 0;
        res.status = 1'b0;
        if (mode == MODE_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) shadow_table[i] = '0;
            shadow_total = '0;
        end else if (mode <= MODE_MMIN) begin
            if (hash_count < rows) begin
                res.status = 1'b1;
            end else begin
                for (int r = 0; r < rows; r++) begin
                    k = (hashes[r] % w) + longint'(r) * w;
                    slot[r] = (k < DEPTH) ? int'(k) : 0;
                end
                if (mode <= MODE_MIN) begin
                    m = longint'(INT_MAX);
                    for (int r = 0; r < rows; r++) begin
                        c = shadow_table[slot[r]];
                        if (mode == MODE_ADD) c = clamp32(c + amount);
                        else if (mode == MODE_REMOVE) c = clamp32(c - amount);
                        shadow_table[slot[r]] = c[31:0];
                        if (c < m) m = c;
                    end
                    if (mode == MODE_ADD)
                        shadow_total = clamp32(longint'(shadow_total) + amount);
                    else if (mode == MODE_REMOVE)
                        shadow_total = clamp32(longint'(shadow_total) - amount);
                    est = m;
                end else if (mode == MODE_MEAN) begin
                    t = 0;
                    for (int r = 0; r < rows; r++) t += shadow_table[slot[r]];
                    est = t / rows;
                end else begin
                    // Correct each counter by the spread of the total, then take the median
                    for (int r = 0; r < rows; r++) begin
                        c = shadow_table[slot[r]];
                        vals[r] = c - ((longint'(shadow_total) - c) / longint'(w - 1));
                    end
                    for (int a = 1; a < rows; a++) begin
                        t = vals[a];
                        b = a;
                        while (b > 0 && vals[b - 1] > t) begin
                            vals[b] = vals[b - 1];
                            b--;
                        end
                        vals[b] = t;
                    end
                    if (rows % 2 == 0) est = (vals[rows / 2] + vals[rows / 2 - 1]) / 2;
                    else est = vals[rows / 2];
                end
            end
        end
        res.estimate = clamp32(est);
        return res;
    endfunction

    // Offer one item, hold it until transfer, record its expected result
    task automatic send_item(input logic [2:0] mode, input logic [30:0] amount,
                             input logic [2:0] hash_count, input hash_set_t hashes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {3'b000, hashes, hash_count, amount, mode};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(sketch_apply(mode, amount, hash_count, hashes));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [10:0] value);
        drain_results();
        cfg_index = idx;
        cfg_wdata = value;
        cfg_we    = 1'b1;
        if (idx == REG_ROW_WIDTH) shadow_width_reg = value;
        else shadow_rows_reg = value[2:0];
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_geometry(input logic [10:0] width, input logic [10:0] rows);
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_ROW_COUNT, rows);
    endtask

    function automatic hash_set_t same_hash(input logic [63:0] h);
        return {h, h, h, h};
    endfunction

    function automatic hash_set_t random_hashes();
        hash_set_t h;
        for (int r = 0; r < 4; r++) h[r] = {$urandom, $urandom};
        return h;
    endfunction

    // Drive the receiver ready, honoring a long hold-off when one is requested
    always @(negedge aclk) begin
        if (recv_hold_cycles > 0) begin
            m_tready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        sketch_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result estimate=%0d status=%0b", $time,
                         $signed(m_tdata[31:0]), m_tdata[32]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[31:0] !== want.estimate)
                    begin
                    $display("%0t: estimate mismatch expected=%0d actual=%0d", $time,
                             want.estimate, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[32] !== want.status) begin
                    $display("%0t: status mismatch expected=%0b actual=%0b", $time,
                             want.status, m_tdata[32]);
                    error_count++;
                end
            end
        end
    end

    // Extremes of every field, every operation, saturation and short hashes
    task automatic test_directed();
        set_geometry(11'd8, 11'd4);
        send_item(MODE_ADD, 31'h7fff_ffff, 3'd4, same_hash(64'd3));
        send_item(MODE_ADD, 31'h7fff_ffff, 3'd4, same_hash(64'd3));
        send_item(MODE_MIN, 31'd0, 3'd7, same_hash(64'd11));
        send_item(MODE_MEAN, 31'd0, 3'd4, {64'd1, 64'd2, 64'd3, 64'd11});
        send_item(MODE_MMIN, 31'd0, 3'd4, {64'd1, 64'd2, 64'd3, 64'd11});
        send_item(MODE_REMOVE, 31'h7fff_ffff, 3'd4, same_hash(64'hffff_ffff_ffff_ffff));
        send_item(MODE_REMOVE, 31'h7fff_ffff, 3'd4, same_hash(64'hffff_ffff_ffff_ffff));
        send_item(MODE_REMOVE, 31'h7fff_ffff, 3'd4, same_hash(64'hffff_ffff_ffff_ffff));
        send_item(MODE_REMOVE, 31'h7fff_ffff, 3'd4, same_hash(64'hffff_ffff_ffff_ffff));
        send_item(MODE_MMIN, 31'd0, 3'd4, same_hash(64'd7));
        send_item(MODE_MEAN, 31'd0, 3'd4, {64'd0, 64'd7, 64'd0, 64'd7});
        send_item(MODE_ADD, 31'd5, 3'd3, same_hash(64'd0));
        send_item(MODE_MIN, 31'd0, 3'd0, same_hash(64'd0));
        send_item(MODE_SPARE_6, 31'h7fff_ffff, 3'd4, same_hash(64'd1));
        send_item(MODE_SPARE_7, 31'd1, 3'd0, same_hash(64'd1));
        send_item(MODE_CLEAR, 31'd9, 3'd0, same_hash(64'd0));
        send_item(MODE_MMIN, 31'd0, 3'd4, same_hash(64'd3));
        // Odd row count and the narrowest rows
        set_geometry(11'd2, 11'd3);
        send_item(MODE_ADD, 31'd100, 3'd3, {64'd0, 64'd1, 64'd0, 64'd1});
        send_item(MODE_ADD, 31'd40, 3'd3, {64'd0, 64'd0, 64'd1, 64'd0});
        send_item(MODE_MMIN, 31'd0, 3'd3, {64'd0, 64'd1, 64'd0, 64'd1});
        send_item(MODE_MMIN, 31'd0, 3'd2, {64'd0, 64'd1, 64'd0, 64'd1});
        send_item(MODE_CLEAR, 31'd0, 3'd7, same_hash(64'd0));
    endtask

    // Random items over a spread of geometries, keys drawn mostly from a pool
    task automatic test_random(input int count);
        logic [10:0] widths [7] = '{11'd1024, 11'd2, 11'd3, 11'd1023, 11'd0, 11'd2047, 11'd17};
        logic [10:0] rowsel [7] = '{11'd4, 11'd1, 11'd4, 11'd3, 11'd0, 11'h7ff, 11'd2};
        logic [2:0]  mode;
        logic [30:0] amount;
        logic [2:0]  hcount;
        hash_set_t   hashes;
        int pick;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) begin
                pick = $urandom_range(6);
                set_geometry(widths[pick], rowsel[pick]);
            end
            pick = $urandom_range(999);
            if (pick < 400) mode = MODE_ADD;
            else if (pick < 550) mode = MODE_REMOVE;
            else if (pick < 680) mode = MODE_MIN;
            else if (pick < 800) mode = MODE_MEAN;
            else if (pick < 960) mode = MODE_MMIN;
            else if (pick < 964) mode = MODE_CLEAR;
            else mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
            pick = $urandom_range(9);
            if (pick < 6) amount = 31'($urandom_range(1000));
            else if (pick < 8) amount = 31'($urandom);
            else amount = 31'h7fff_ffff - 31'($urandom_range(3));
            hcount = ($urandom_range(9) < 8) ? 3'd4 : 3'($urandom_range(7));
            hashes = ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)] : random_hashes();
            send_item(mode, amount, hcount, hashes);
        end
    endtask

    // Hold the receiver off for a long stretch while items keep coming
    task automatic test_backpressure();
        set_geometry(11'd64, 11'd2);
        recv_hold_cycles = 3000;
        for (int i = 0; i < 20; i++)
            send_item(($urandom_range(1) ? MODE_ADD : MODE_MMIN), 31'($urandom_range(50)),
                      3'd4, key_pool[$urandom_range(3)]);
    endtask

    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) shadow_table[i] = '0;
        shadow_total = '0;
        shadow_width_reg = 11'd1024;
        shadow_rows_reg = 3'd4;
        for (int k = 0; k < 16; k++) begin
            for (int r = 0; r < 4; r++)
                key_pool[k][r] = (k < 8) ? 64'($urandom_range(40)) : {$urandom, $urandom};
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        send_idle_pct = 33;
        recv_idle_pct = 76;
        test_random(440);
        send_idle_pct = 76;
        recv_idle_pct = 33;
        test_random(440);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(440);

        drain_results();
        repeat (500) @(negedge aclk);
        $display("Run covered %0d items and %0d checked results over all modes,", items_sent,
                 results_checked);
        $display("register extremes, saturation, short hash sets and a long output stall.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/cms_pkg.sv
rtl/cms_div.sv
rtl/count_min_sketch_engine.sv
dv/count_min_sketch_engine_tb.sv
